[src/srtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, field widths and codes for the SRTF tick scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int TIME_BITS_DEF = 16;

   localparam int ACTION_W  = 2;
   localparam int SLOT_W    = 4;
   localparam int BURST_W   = 12;
   localparam int ARRIVAL_W = 15;
   localparam int PRIO_W    = 4;
   localparam int RSP_W     = 16;

   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_LAST = 5'b00100,
      ST_CALC = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

endpackage

[src/srtf_tick_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over a table of job slots.
// Load and clear take effect in the accept cycle; a tick holds busy while it
// makes one table read per slot through a single compare unit, then updates
// and finishes, its result strobed in the cycle after the finish state.
// Loads and clears one per cycle while idle; no request is taken while busy.
// Reset (synchronous) empties the table and zeroes time; the receiver cannot stall.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_top #(
   parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
   parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [srtf_pkg::ACTION_W-1:0]    req_action,
   input  logic [srtf_pkg::SLOT_W-1:0]      req_slot,
   input  logic [srtf_pkg::BURST_W-1:0]     req_burst,
   input  logic [srtf_pkg::ARRIVAL_W-1:0]   req_arrival,
   input  logic [srtf_pkg::PRIO_W-1:0]      req_prio,
   output logic                             rsp_valid,
   output logic                             rsp_idle,
   output logic [srtf_pkg::SLOT_W-1:0]      rsp_ran_slot,
   output logic                             rsp_finished,
   output logic [srtf_pkg::RSP_W-1:0]       rsp_turnaround,
   output logic [srtf_pkg::RSP_W-1:0]       rsp_waiting,
   output logic                             rsp_all_done,
   output logic [srtf_pkg::RSP_W-1:0]       rsp_now
);
   import srtf_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   // wide enough for time, arrival and any value that saturates to 16 bits
   localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CMP_W-1:0] SAT_LIM  = CMP_W'(17'h0FFFF);

   // slot table
   logic [BURST_W-1:0]   burst_mem   [SLOTS];
   logic [ARRIVAL_W-1:0] arrival_mem [SLOTS];
   logic [PRIO_W-1:0]    prio_mem    [SLOTS];
   logic [BURST_W-1:0]   rem_mem     [SLOTS];

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;

   // registered read port
   logic [BURST_W-1:0]   rd_burst_ff;
   logic [ARRIVAL_W-1:0] rd_arrival_ff;
   logic [PRIO_W-1:0]    rd_prio_ff;
   logic [BURST_W-1:0]   rd_rem_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 cmp_vld_ff, cmp_vld_in;

   // running best candidate
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [BURST_W-1:0]   best_rem_ff, best_rem_in;
   logic [PRIO_W-1:0]    best_prio_ff, best_prio_in;
   logic [ARRIVAL_W-1:0] best_arrival_ff, best_arrival_in;
   logic [BURST_W-1:0]   best_burst_ff, best_burst_in;
   logic [1:0]           live_cnt_ff, live_cnt_in;

   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CMP_W-1:0]     turn_ff, turn_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_idle_ff, rsp_idle_in;
   logic [SLOT_W-1:0]    rsp_ran_slot_ff, rsp_ran_slot_in;
   logic                 rsp_finished_ff, rsp_finished_in;
   logic [RSP_W-1:0]     rsp_turnaround_ff, rsp_turnaround_in;
   logic [RSP_W-1:0]     rsp_waiting_ff, rsp_waiting_in;
   logic                 rsp_all_done_ff, rsp_all_done_in;
   logic [RSP_W-1:0]     rsp_now_ff, rsp_now_in;

   logic                 accept;
   logic                 load_wr;
   logic [IDX_W-1:0]     load_idx;
   logic                 rem_dec_wr;
   logic                 live;
   logic                 eligible;
   logic                 better;
   logic [CMP_W-1:0]     wait_full;

   assign accept   = start && !busy;
   assign load_idx = IDX_W'(req_slot);
   assign load_wr  = accept && (req_action == ACT_LOAD) && (32'(req_slot) < SLOTS);

   assign live     = rd_valid_ff && (rd_rem_ff != '0);
   assign eligible = live && (CMP_W'(rd_arrival_ff) <= CMP_W'(time_ff));
   assign better   = !found_ff || (rd_rem_ff < best_rem_ff) ||
                     ((rd_rem_ff == best_rem_ff) && (rd_prio_ff < best_prio_ff));

   assign rem_dec_wr = (state_ff == ST_CALC) && found_ff;
   assign wait_full  = turn_ff - CMP_W'(best_burst_ff);

   always_comb begin
      state_in          = state_ff;
      valid_in          = valid_ff;
      time_in           = time_ff;
      addr_in           = addr_ff;
      cmp_vld_in        = (state_ff == ST_SCAN);
      found_in          = found_ff;
      best_idx_in       = best_idx_ff;
      best_rem_in       = best_rem_ff;
      best_prio_in      = best_prio_ff;
      best_arrival_in   = best_arrival_ff;
      best_burst_in     = best_burst_ff;
      live_cnt_in       = live_cnt_ff;
      fin_in            = fin_ff;
      done_in           = done_ff;
      turn_in           = turn_ff;
      rsp_valid_in      = 1'b0;
      rsp_idle_in       = rsp_idle_ff;
      rsp_ran_slot_in   = rsp_ran_slot_ff;
      rsp_finished_in   = rsp_finished_ff;
      rsp_turnaround_in = rsp_turnaround_ff;
      rsp_waiting_in    = rsp_waiting_ff;
      rsp_all_done_in   = rsp_all_done_ff;
      rsp_now_in        = rsp_now_ff;

      // fold one table entry per cycle into the best candidate
      if (cmp_vld_ff) begin
         if (live && (live_cnt_ff != 2'd2)) begin
            live_cnt_in = live_cnt_ff + 2'd1;
         end
         if (eligible && better) begin
            found_in        = 1'b1;
            best_idx_in     = cmp_idx_ff;
            best_rem_in     = rd_rem_ff;
            best_prio_in    = rd_prio_ff;
            best_arrival_in = rd_arrival_ff;
            best_burst_in   = rd_burst_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (load_wr) begin
                  valid_in[load_idx] = 1'b1;
               end
               if (req_action == ACT_CLEAR) begin
                  valid_in = '0;
                  time_in  = '0;
               end
               if (req_action == ACT_TICK) begin
                  addr_in     = '0;
                  found_in    = 1'b0;
                  live_cnt_in = 2'd0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (time_ff != '1) begin
               time_in = time_ff + 1'b1;
            end
            fin_in  = found_ff && (best_rem_ff == BURST_W'(1));
            turn_in = CMP_W'(time_in) - CMP_W'(best_arrival_ff);
            // best job was live, so it alone leaves the table empty when it ends
            done_in = (live_cnt_ff == 2'd0) ||
                      (found_ff && (best_rem_ff == BURST_W'(1)) && (live_cnt_ff == 2'd1));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in      = 1'b1;
            rsp_idle_in       = !found_ff;
            rsp_ran_slot_in   = found_ff ? SLOT_W'(best_idx_ff) : '0;
            rsp_finished_in   = fin_ff;
            rsp_turnaround_in = '0;
            rsp_waiting_in    = '0;
            if (fin_ff) begin
               rsp_turnaround_in = (turn_ff > SAT_LIM) ? '1 : RSP_W'(turn_ff);
               if (turn_ff >= CMP_W'(best_burst_ff)) begin
                  rsp_waiting_in = (wait_full > SAT_LIM) ? '1 : RSP_W'(wait_full);
               end
            end
            rsp_all_done_in = done_ff;
            rsp_now_in      = RSP_W'(time_ff);
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         time_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         time_ff      <= time_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      addr_ff           <= addr_in;
      found_ff          <= found_in;
      best_idx_ff       <= best_idx_in;
      best_rem_ff       <= best_rem_in;
      best_prio_ff      <= best_prio_in;
      best_arrival_ff   <= best_arrival_in;
      best_burst_ff     <= best_burst_in;
      live_cnt_ff       <= live_cnt_in;
      fin_ff            <= fin_in;
      done_ff           <= done_in;
      turn_ff           <= turn_in;
      rsp_idle_ff       <= rsp_idle_in;
      rsp_ran_slot_ff   <= rsp_ran_slot_in;
      rsp_finished_ff   <= rsp_finished_in;
      rsp_turnaround_ff <= rsp_turnaround_in;
      rsp_waiting_ff    <= rsp_waiting_in;
      rsp_all_done_ff   <= rsp_all_done_in;
      rsp_now_ff        <= rsp_now_in;
   end

   // table write port: load writes the whole entry, a tick decrements remaining
   always_ff @(posedge clock) begin
      if (load_wr) begin
         burst_mem[load_idx]   <= req_burst;
         arrival_mem[load_idx] <= req_arrival;
         prio_mem[load_idx]    <= req_prio;
         rem_mem[load_idx]     <= req_burst;
      end else if (rem_dec_wr) begin
         rem_mem[best_idx_ff]  <= best_rem_ff - 1'b1;
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      rd_burst_ff   <= burst_mem[addr_ff];
      rd_arrival_ff <= arrival_mem[addr_ff];
      rd_prio_ff    <= prio_mem[addr_ff];
      rd_rem_ff     <= rem_mem[addr_ff];
      rd_valid_ff   <= valid_ff[addr_ff];
      cmp_idx_ff    <= addr_ff;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_idle       = rsp_idle_ff;
   assign rsp_ran_slot   = rsp_ran_slot_ff;
   assign rsp_finished   = rsp_finished_ff;
   assign rsp_turnaround = rsp_turnaround_ff;
   assign rsp_waiting    = rsp_waiting_ff;
   assign rsp_all_done   = rsp_all_done_ff;
   assign rsp_now        = rsp_now_ff;

endmodule

[dv/tb_srtf_tick_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srtf_tick_scheduler_top
// Self-checking bench for the SRTF tick scheduler: a local schedule predictor
// tracks the job table and time, directed tests cover extremes, preemption,
// tie breaks, reloads, zero bursts and late arrivals, and random job mixes
// with idle gaps exercise the rest. Every tick result is checked field by field.
// ----------------------------------------------------------------------------
module tb_srtf_tick_scheduler_top;
   import srtf_pkg::*;

   localparam int SLOTS       = SLOTS_DEF;
   localparam int TIME_BITS   = TIME_BITS_DEF;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 400;
   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_ITEMS  = 100;

   typedef struct packed {
      logic             idle;
      logic [SLOT_W-1:0] ran_slot;
      logic             finished;
      logic [RSP_W-1:0] turnaround;
      logic [RSP_W-1:0] waiting;
      logic             all_done;
      logic [RSP_W-1:0] now;
   } tick_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ACTION_W-1:0]  req_action;
   logic [SLOT_W-1:0]    req_slot;
   logic [BURST_W-1:0]   req_burst;
   logic [ARRIVAL_W-1:0] req_arrival;
   logic [PRIO_W-1:0]    req_prio;
   logic                 rsp_valid;
   logic                 rsp_idle;
   logic [SLOT_W-1:0]    rsp_ran_slot;
   logic                 rsp_finished;
   logic [RSP_W-1:0]     rsp_turnaround;
   logic [RSP_W-1:0]     rsp_waiting;
   logic                 rsp_all_done;
   logic [RSP_W-1:0]     rsp_now;

   // predictor copy of the job table
   bit                   job_valid [SLOTS];
   logic [BURST_W-1:0]   job_burst [SLOTS];
   logic [BURST_W-1:0]   job_remaining [SLOTS];
   logic [ARRIVAL_W-1:0] job_arrival [SLOTS];
   logic [PRIO_W-1:0]    job_prio [SLOTS];
   logic [TIME_BITS-1:0] sched_time;

   tick_result_type expected_ticks[$];
   int           fail_count;
   int           stall_cycles;
   bit           idling_on;

   srtf_tick_scheduler_top DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_slot       (req_slot),
      .req_burst      (req_burst),
      .req_arrival    (req_arrival),
      .req_prio       (req_prio),
      .rsp_valid      (rsp_valid),
      .rsp_idle       (rsp_idle),
      .rsp_ran_slot   (rsp_ran_slot),
      .rsp_finished   (rsp_finished),
      .rsp_turnaround (rsp_turnaround),
      .rsp_waiting    (rsp_waiting),
      .rsp_all_done   (rsp_all_done),
      .rsp_now        (rsp_now)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [RSP_W-1:0] sat16(input longint v);
      return (v > 65535) ? 16'hFFFF : v[RSP_W-1:0];
   endfunction

   // update the job table and time, queue the tick outcome
   task automatic predict_schedule(input logic [ACTION_W-1:0] act,
                                   input logic [SLOT_W-1:0] slot,
                                   input logic [BURST_W-1:0] burst,
                                   input logic [ARRIVAL_W-1:0] arrival,
                                   input logic [PRIO_W-1:0] prio);
      tick_result_type res;
      bit           found;
      int           best;
      longint       span;
      found = 0;
      best  = 0;
      res   = '0;
      case (act)
         ACT_LOAD: begin
            job_valid[slot]     = 1'b1;
            job_burst[slot]     = burst;
            job_arrival[slot]   = arrival;
            job_prio[slot]      = prio;
            job_remaining[slot] = burst;
         end
         ACT_CLEAR: begin
            foreach (job_valid[i]) job_valid[i] = 1'b0;
            sched_time = '0;
         end
         ACT_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (job_valid[i] && job_remaining[i] != 0 &&
                   TIME_BITS'(job_arrival[i]) <= sched_time) begin
                  if (!found || job_remaining[i] < job_remaining[best]) begin
                     found = 1;
                     best  = i;
                  end else if (job_remaining[i] == job_remaining[best] &&
                               job_prio[i] < job_prio[best]) begin
                     best = i;
                  end
               end
            end
            if (sched_time != TIME_MAX) sched_time++;
            res.idle = !found;
            if (found) begin
               res.ran_slot = best[SLOT_W-1:0];
               job_remaining[best]--;
               if (job_remaining[best] == 0) begin
                  span           = longint'(sched_time) - longint'(job_arrival[best]);
                  res.finished   = 1'b1;
                  res.turnaround = sat16(span);
                  res.waiting    = (span >= job_burst[best]) ?
                                   sat16(span - job_burst[best]) : '0;
               end
            end
            res.all_done = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               if (job_valid[i] && job_remaining[i] != 0) res.all_done = 1'b0;
            end
            res.now = RSP_W'(sched_time);
            expected_ticks.push_back(res);
         end
         default: ;
      endcase
   endtask

   task automatic idle_gap();
      int n;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [SLOT_W-1:0] slot,
                               input logic [BURST_W-1:0] burst,
                               input logic [ARRIVAL_W-1:0] arrival,
                               input logic [PRIO_W-1:0] prio);
      idle_gap();
      @(negedge clock);
      start       <= 1'b1;
      req_action  <= act;
      req_slot    <= slot;
      req_burst   <= burst;
      req_arrival <= arrival;
      req_prio    <= prio;
      do @(posedge clock); while (busy);
      predict_schedule(act, slot, burst, arrival, prio);
   endtask

   task automatic send_tick();
      send_request(ACT_TICK, SLOT_W'($urandom), BURST_W'($urandom),
                   ARRIVAL_W'($urandom), PRIO_W'($urandom));
   endtask

   task automatic send_clear();
      send_request(ACT_CLEAR, SLOT_W'($urandom), BURST_W'($urandom),
                   ARRIVAL_W'($urandom), PRIO_W'($urandom));
   endtask

   task automatic check_field(input string name, input logic [RSP_W-1:0] exp_val,
                              input logic [RSP_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name,
                  exp_val, act_val);
         fail_count++;
      end
   endtask

   // compare each strobed result against the oldest pending prediction
   always @(posedge clock) begin
      tick_result_type exp_res;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t: unexpected result, expected none actual slot %0d now %0d",
                     $realtime, rsp_ran_slot, rsp_now);
            fail_count++;
         end else begin
            exp_res = expected_ticks.pop_front();
            check_field("idle", RSP_W'(exp_res.idle), RSP_W'(rsp_idle));
            check_field("ran_slot", RSP_W'(exp_res.ran_slot), RSP_W'(rsp_ran_slot));
            check_field("finished", RSP_W'(exp_res.finished), RSP_W'(rsp_finished));
            check_field("turnaround", exp_res.turnaround, rsp_turnaround);
            check_field("waiting", exp_res.waiting, rsp_waiting);
            check_field("all_done", RSP_W'(exp_res.all_done), RSP_W'(rsp_all_done));
            check_field("now", exp_res.now, rsp_now);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || reset) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("srtf_tick_scheduler_top test failed");
            $finish;
         end
      end
   end

   task automatic test_empty_table();
      send_tick();
      send_tick();
   endtask

   task automatic test_field_extremes();
      send_clear();
      send_request(ACT_LOAD, 4'd15, 12'd4095, 15'd32767, 4'd15);
      send_request(ACT_LOAD, 4'd0, 12'd1, 15'd0, 4'd0);
      send_tick();
      send_tick();
   endtask

   task automatic test_preemption_and_ties();
      send_clear();
      send_request(ACT_LOAD, 4'd3, 12'd4, 15'd0, 4'd6);
      send_tick();
      // shorter job arrives later and takes over
      send_request(ACT_LOAD, 4'd7, 12'd1, 15'd1, 4'd9);
      send_tick();
      send_request(ACT_LOAD, 4'd5, 12'd3, 15'd0, 4'd6);
      send_request(ACT_LOAD, 4'd2, 12'd3, 15'd0, 4'd6);
      send_request(ACT_LOAD, 4'd9, 12'd3, 15'd0, 4'd1);
      repeat (5) send_tick();
   endtask

   task automatic test_special_cases();
      send_clear();
      send_request(ACT_LOAD, 4'd4, 12'd6, 15'd0, 4'd1);
      send_tick();
      // overwrite a live slot; it restarts from the new burst
      send_request(ACT_LOAD, 4'd4, 12'd2, 15'd0, 4'd3);
      send_request(ACT_UNUSED, 4'd4, 12'd1, 15'd0, 4'd0);
      send_request(ACT_LOAD, 4'd6, 12'd0, 15'd0, 4'd0);
      repeat (3) send_tick();
   endtask

   task automatic test_late_arrival();
      send_clear();
      // jobs far in the future stay ineligible
      send_request(ACT_LOAD, 4'd1, 12'd2, 15'd32767, 4'd2);
      send_request(ACT_LOAD, 4'd8, 12'd3, 15'd32767, 4'd0);
      repeat (4) send_tick();
      send_request(ACT_LOAD, 4'd0, 12'd3, 15'd0, 4'd0);
      repeat (4) send_tick();
   endtask

   task automatic test_random_traffic();
      int items_sent;
      int jobs;
      int ticks;
      logic [BURST_W-1:0]   burst;
      logic [ARRIVAL_W-1:0] arrival;
      items_sent = 0;
      send_clear();
      while (items_sent < RANDOM_ITEMS) begin
         idling_on = (items_sent < RANDOM_ITEMS - QUIET_ITEMS);
         if ($urandom_range(0, 2) == 0) begin
            send_clear();
            items_sent++;
         end
         if ($urandom_range(0, 9) == 0) send_request(ACT_UNUSED, SLOT_W'($urandom),
                                                     BURST_W'($urandom),
                                                     ARRIVAL_W'($urandom),
                                                     PRIO_W'($urandom));
         jobs = $urandom_range(0, 6);
         repeat (jobs) begin
            burst = ($urandom_range(0, 9) == 0) ? BURST_W'($urandom_range(1, 4095)) :
                                                  BURST_W'($urandom_range(1, 12));
            arrival = ($urandom_range(0, 7) == 0) ? ARRIVAL_W'($urandom) :
                      ARRIVAL_W'(sched_time) + ARRIVAL_W'($urandom_range(0, 8));
            send_request(ACT_LOAD, SLOT_W'($urandom), burst, arrival, PRIO_W'($urandom));
            items_sent++;
         end
         ticks = $urandom_range(2, 30);
         repeat (ticks) send_tick();
         items_sent += ticks;
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_action  = ACT_LOAD;
      req_slot    = '0;
      req_burst   = '0;
      req_arrival = '0;
      req_prio    = '0;
      fail_count  = 0;
      idling_on   = 1'b1;
      foreach (job_valid[i]) job_valid[i] = 1'b0;
      sched_time  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_field_extremes();
      test_preemption_and_ties();
      test_special_cases();
      idling_on = 1'b0;
      test_late_arrival();
      idling_on = 1'b1;
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (SLOTS + 6) @(posedge clock);
      if (fail_count == 0) begin
         $display("srtf_tick_scheduler_top test passed");
      end else begin
         $display("srtf_tick_scheduler_top test failed");
      end
      $finish;
   end

endmodule

[srtf_tick_scheduler_top.f]
src/srtf_pkg.sv
src/srtf_tick_scheduler_top.sv
dv/tb_srtf_tick_scheduler_top.sv
